@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Depends on nothing; users provide aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while in reset.
`define QPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define QPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/qpd_pkg.sv @@
// Constants, codes and helper functions for the quoted-printable decoder.
// Depends on nothing.
package qpd_pkg;

    localparam int MAX_HEADER_DEF = 48;
    localparam int RES_MAX        = 52;
    localparam int RES_W          = $clog2(RES_MAX + 1);

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        HP_IDLE, HP_EQ, HP_CHARSET, HP_LETTER, HP_FINAL
    } hdr_phase_t;

    typedef enum logic [1:0] {
        ES_IDLE, ES_EQ, ES_DIGIT, ES_QMARK
    } esc_phase_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_space(input logic [7:0] c);
        return (c < CH_SPACE) ? CH_SPACE : c;
    endfunction

endpackage

@@ rtl/qpd_stream_ram.sv @@
// Byte stream memory: one write port, one read port, registered read data.
// Depends on nothing.
module qpd_stream_ram #(
    parameter int AW = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [2**AW];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/quoted_printable_decoder_core.sv @@
// Quoted-printable / Q-section decoder. A word goes through accept, memory read, decode
// and empty check; it passes S_ISSUE and S_PROC before its first result is registered,
// and a held '?' sent ahead of a byte repeats the decode step. A failed opener replays
// its held bytes, read again from the stream memory; a final word flushes via S_END and
// S_FLUSH. Output back-pressure stalls decoding. Synchronous active-low reset clears
// all control state; the stream memory is not cleared, only bytes written since are read.
`include "assert_macros.svh"
module quoted_printable_decoder_core #(
    parameter int MAX_HEADER = qpd_pkg::MAX_HEADER_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_end_of_text
);
    localparam int AW = $clog2(MAX_HEADER + 2);
    localparam int CW = $clog2(MAX_HEADER + 1);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_PROC, S_END, S_FLUSH} state_t;

    state_t                 state_reg, state_next;
    logic                   qp_mode_reg;
    logic [AW-1:0]          wp_reg, rp_reg, rp_next, hs_reg, hs_next, pos_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    qpd_pkg::hdr_phase_t    hp_reg, hp_next;
    qpd_pkg::esc_phase_t    esc_reg, esc_next;
    logic                   q_reg, q_next;
    logic [3:0]             fd_reg, fd_next;
    logic                   last_reg;
    logic [qpd_pkg::RES_W-1:0] rn_reg;
    logic                   pend_v_reg, pend_v_next;
    logic [7:0]             pend_b_reg, pend_b_next;
    logic                   m_valid_reg;
    logic [7:0]             m_byte_reg;
    logic                   m_bv_reg, m_eot_reg;

    logic       accept, rd_en, emit_req, emit_do, push_out, can_emit, stall;
    logic [7:0] emit_b, rd_byte, out_b;
    logic       out_bv, out_eot;
    logic [4:0] hx;
    logic       fail;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign can_emit = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == S_ISSUE) && (rp_reg != wp_reg);
    assign hx       = qpd_pkg::hex_decode(rd_byte);

    qpd_stream_ram #(.AW(AW)) u_ram (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_in_byte),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_byte)
    );

    always_comb begin
        state_next  = state_reg;
        rp_next     = rp_reg;
        hs_next     = hs_reg;
        cnt_next    = cnt_reg;
        hp_next     = hp_reg;
        esc_next    = esc_reg;
        q_next      = q_reg;
        fd_next     = fd_reg;
        emit_req    = 1'b0;
        emit_b      = '0;
        fail        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (rp_reg != wp_reg) begin
                    rp_next    = rp_reg + AW'(1);
                    state_next = S_PROC;
                end else if (last_reg && hp_reg != qpd_pkg::HP_IDLE) begin
                    fail = 1'b1;
                end else if (last_reg) begin
                    state_next = S_END;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PROC: begin
                state_next = S_ISSUE;
                if (esc_reg == qpd_pkg::ES_EQ && hx[4]) begin
                    fd_next  = hx[3:0];
                    esc_next = qpd_pkg::ES_DIGIT;
                end else if (esc_reg == qpd_pkg::ES_EQ && rd_byte <= qpd_pkg::CH_SPACE) begin
                    esc_next = qpd_pkg::ES_IDLE;
                end else if (esc_reg == qpd_pkg::ES_DIGIT) begin
                    esc_next = qpd_pkg::ES_IDLE;
                    emit_req = 1'b1;
                    emit_b   = hx[4] ? qpd_pkg::clamp_space({fd_reg, hx[3:0]})
                                     : qpd_pkg::clamp_space({4'h0, fd_reg});
                end else if (esc_reg == qpd_pkg::ES_QMARK) begin
                    esc_next = qpd_pkg::ES_IDLE;
                    if (rd_byte == qpd_pkg::CH_EQ) begin
                        q_next = 1'b0;
                    end else begin
                        // send the held '?', then look at this byte again
                        emit_req   = 1'b1;
                        emit_b     = qpd_pkg::CH_QMARK;
                        state_next = S_PROC;
                    end
                end else begin
                    // escape idle here (a non-hex after '=' falls through too)
                    esc_next = qpd_pkg::ES_IDLE;
                    if (hp_reg != qpd_pkg::HP_IDLE) begin
                        case (hp_reg)
                            qpd_pkg::HP_EQ: begin
                                if (rd_byte == qpd_pkg::CH_QMARK && 32'(cnt_reg) < MAX_HEADER) begin
                                    cnt_next = cnt_reg + CW'(1);
                                    hp_next  = qpd_pkg::HP_CHARSET;
                                end else begin
                                    fail = 1'b1;
                                end
                            end
                            qpd_pkg::HP_CHARSET: begin
                                if (32'(cnt_reg) < MAX_HEADER) begin
                                    cnt_next = cnt_reg + CW'(1);
                                    if (rd_byte == qpd_pkg::CH_QMARK) begin
                                        hp_next = qpd_pkg::HP_LETTER;
                                    end
                                end else begin
                                    fail = 1'b1;
                                end
                            end
                            qpd_pkg::HP_LETTER: begin
                                if (rd_byte == qpd_pkg::CH_Q && 32'(cnt_reg) < MAX_HEADER) begin
                                    cnt_next = cnt_reg + CW'(1);
                                    hp_next  = qpd_pkg::HP_FINAL;
                                end else begin
                                    fail = 1'b1;
                                end
                            end
                            qpd_pkg::HP_FINAL: begin
                                if (rd_byte == qpd_pkg::CH_QMARK) begin
                                    q_next   = 1'b1;
                                    hp_next  = qpd_pkg::HP_IDLE;
                                    cnt_next = '0;
                                end else begin
                                    fail = 1'b1;
                                end
                            end
                            default: fail = 1'b1;
                        endcase
                    end else if (rd_byte == qpd_pkg::CH_EQ) begin
                        hs_next  = pos_reg;
                        cnt_next = CW'(1);
                        hp_next  = qpd_pkg::HP_EQ;
                    end else if (rd_byte == qpd_pkg::CH_QMARK && q_reg) begin
                        esc_next = qpd_pkg::ES_QMARK;
                    end else begin
                        emit_req = 1'b1;
                        emit_b   = rd_byte;
                    end
                end
            end
            S_END: begin
                if (esc_reg == qpd_pkg::ES_DIGIT) begin
                    emit_req = 1'b1;
                    emit_b   = qpd_pkg::clamp_space({4'h0, fd_reg});
                end else if (esc_reg == qpd_pkg::ES_QMARK) begin
                    emit_req = 1'b1;
                    emit_b   = qpd_pkg::CH_QMARK;
                end
                esc_next   = qpd_pkg::ES_IDLE;
                fd_next    = '0;
                q_next     = 1'b0;
                hp_next    = qpd_pkg::HP_IDLE;
                cnt_next   = '0;
                state_next = S_FLUSH;
            end
            S_FLUSH: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // opener rejected: bytes after '=' are read again; '=' is sent or, in QP/Q, escapes
        if (fail) begin
            rp_next  = hs_reg + AW'(1);
            hp_next  = qpd_pkg::HP_IDLE;
            cnt_next = '0;
            if (qp_mode_reg || q_reg) begin
                esc_next = qpd_pkg::ES_EQ;
            end else begin
                emit_req = 1'b1;
                emit_b   = qpd_pkg::CH_EQ;
            end
        end
    end

    // Result routing: at most RES_MAX results a word are kept; within a final word
    // the newest result is held back so the end flag can go on it.
    always_comb begin
        emit_do     = emit_req && (rn_reg < qpd_pkg::RES_W'(qpd_pkg::RES_MAX));
        push_out    = 1'b0;
        out_b       = emit_b;
        out_bv      = 1'b1;
        out_eot     = 1'b0;
        pend_v_next = pend_v_reg;
        pend_b_next = pend_b_reg;
        if (state_reg == S_FLUSH) begin
            push_out    = 1'b1;
            out_b       = pend_v_reg ? pend_b_reg : 8'h00;
            out_bv      = pend_v_reg;
            out_eot     = 1'b1;
            pend_v_next = 1'b0;
        end else if (emit_do) begin
            if (last_reg) begin
                push_out    = pend_v_reg;
                out_b       = pend_b_reg;
                pend_v_next = 1'b1;
                pend_b_next = emit_b;
            end else begin
                push_out = 1'b1;
            end
        end
        stall = push_out && !can_emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            qp_mode_reg <= 1'b0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            hs_reg      <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            hp_reg      <= qpd_pkg::HP_IDLE;
            esc_reg     <= qpd_pkg::ES_IDLE;
            q_reg       <= 1'b0;
            fd_reg      <= '0;
            last_reg    <= 1'b0;
            rn_reg      <= '0;
            pend_v_reg  <= 1'b0;
            pend_b_reg  <= '0;
            m_valid_reg <= 1'b0;
            m_byte_reg  <= '0;
            m_bv_reg    <= 1'b0;
            m_eot_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                qp_mode_reg <= cfg_data;
            end
            if (accept) begin
                wp_reg   <= wp_reg + AW'(1);
                last_reg <= s_in_last;
                rn_reg   <= '0;
            end
            if (rd_en) begin
                pos_reg <= rp_reg;
            end
            if (!stall) begin
                state_reg  <= state_next;
                rp_reg     <= rp_next;
                hs_reg     <= hs_next;
                cnt_reg    <= cnt_next;
                hp_reg     <= hp_next;
                esc_reg    <= esc_next;
                q_reg      <= q_next;
                fd_reg     <= fd_next;
                pend_v_reg <= pend_v_next;
                pend_b_reg <= pend_b_next;
                if (emit_do) begin
                    rn_reg <= rn_reg + qpd_pkg::RES_W'(1);
                end
            end
            if (push_out && !stall) begin
                m_valid_reg <= 1'b1;
                m_byte_reg  <= out_b;
                m_bv_reg    <= out_bv;
                m_eot_reg   <= out_eot;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_byte_valid  = m_bv_reg;
    assign m_end_of_text = m_eot_reg;

    `QPD_ASSERT(a_esc_idle_in_hdr, (hp_reg != qpd_pkg::HP_IDLE) |-> (esc_reg == qpd_pkg::ES_IDLE), "escape active during opener")
    `QPD_ASSERT(a_cnt_range, 32'(cnt_reg) <= MAX_HEADER, "header count past limit")
    `QPD_ASSERT(a_pend_last, pend_v_reg |-> last_reg, "held result outside final word")
    `QPD_ASSERT(a_idle_clean, (state_reg == S_IDLE) |-> (rp_reg == wp_reg || hp_reg != qpd_pkg::HP_IDLE), "unread bytes while idle")
endmodule
